// ===== hdl/ekpc_pkg.sv =====
`default_nettype none

package ekpc_pkg;

  // Sizing defaults
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // MAC header lengths
  localparam logic [5:0] HDR_BASE  = 6'd24;
  localparam logic [5:0] HDR_ADDR4 = 6'd6;
  localparam logic [5:0] HDR_QOS   = 6'd2;
  // SNAP plus EAPOL header, minus one; added to the header length (frame position form)
  localparam logic [5:0] HDR_TAIL  = 6'd11;

  // LLC/SNAP pattern for EtherType 0x888E
  localparam logic [3:0] SNAP_LEN = 4'd8;
  localparam logic [7:0] SNAP_PATTERN [8] = '{
    8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h00, 8'h88, 8'h8E
  };

  // Byte offsets after the MAC header
  localparam logic [3:0] OFF_VERSION = 4'd8;
  localparam logic [3:0] OFF_KIND    = 4'd9;
  localparam logic [3:0] OFF_LEN_HI  = 4'd10;
  localparam logic [3:0] OFF_LEN_LO  = 4'd11;
  localparam logic [3:0] OFF_DESC    = 4'd12;
  localparam logic [3:0] OFF_KI_HI   = 4'd13;
  localparam logic [3:0] OFF_KI_LO   = 4'd14;

  // Frame and packet codes
  localparam logic [1:0] FTYPE_DATA   = 2'd2;
  localparam logic [7:0] KIND_KEY     = 8'd3;
  localparam logic [7:0] VER_MIN      = 8'd1;
  localparam logic [7:0] VER_MAX      = 8'd3;
  localparam logic [15:0] KEY_MIN_BODY = 16'd95;
  localparam logic [7:0] DESC_RC4     = 8'd1;
  localparam logic [7:0] DESC_RSN     = 8'd2;
  localparam logic [7:0] DESC_WPA     = 8'd254;

  // Key information bit positions
  localparam int KI_PAIRWISE = 3;
  localparam int KI_INSTALL  = 6;
  localparam int KI_ACK      = 7;
  localparam int KI_MIC      = 8;
  localparam int KI_SECURE   = 9;
  localparam int KI_ERROR    = 10;
  localparam int KI_REQUEST  = 11;

  // Handshake phase codes
  localparam logic [2:0] PH_NONE  = 3'd0;
  localparam logic [2:0] PH_OTHER = 3'd1;
  localparam logic [2:0] PH_MSG1  = 3'd2;
  localparam logic [2:0] PH_MSG2  = 3'd3;
  localparam logic [2:0] PH_MSG3  = 3'd4;
  localparam logic [2:0] PH_MSG4  = 3'd5;

  // Per-frame summary handed from the parser to the classifier
  typedef struct packed {
    logic [1:0]  ftype;
    logic        snap;
    logic [5:0]  hdr;
    logic [7:0]  version;
    logic [7:0]  kind;
    logic [15:0] body_length;
    logic [7:0]  descriptor;
    logic [15:0] key_info;
  } frame_rec_t;

endpackage

`default_nettype wire

// ===== hdl/ekpc_front.sv =====
`default_nettype none

module ekpc_front
  import ekpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   last_byte_i,
  output      logic                   push_o,
  output      frame_rec_t             rec_o,
  output      logic [COUNT_WIDTH-1:0] pos_o
);

  frame_rec_t             st_q, st_d, upd;
  logic                   qos_q, qos_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] hdr_ext;
  logic [COUNT_WIDTH-1:0] rel;
  logic [3:0]             rel4;
  logic                   in_zone;

  assign hdr_ext = COUNT_WIDTH'(st_q.hdr);
  assign rel     = count_q - hdr_ext;
  assign rel4    = rel[3:0];
  assign in_zone = (count_q >= hdr_ext) && (rel[COUNT_WIDTH-1:4] == '0);

  always_comb begin
    upd     = st_q;
    qos_d   = qos_q;
    count_d = count_q;
    if (count_q == '0) begin
      upd.ftype = data_byte_i[3:2];
      upd.snap  = 1'b1;
      qos_d     = data_byte_i[7];
    end else if (count_q == COUNT_WIDTH'(1)) begin
      upd.hdr = HDR_BASE + ((data_byte_i[1:0] == 2'b11) ? HDR_ADDR4 : 6'd0)
              + (qos_q ? HDR_QOS : 6'd0);
    end else if (in_zone) begin
      if (rel4 < SNAP_LEN) begin
        if (data_byte_i != SNAP_PATTERN[rel4[2:0]]) begin
          upd.snap = 1'b0;
        end
      end else begin
        case (rel4)
          OFF_VERSION: upd.version                 = data_byte_i;
          OFF_KIND:    upd.kind                    = data_byte_i;
          OFF_LEN_HI:  upd.body_length[15:8]       = data_byte_i;
          OFF_LEN_LO:  upd.body_length[7:0]        = data_byte_i;
          OFF_DESC:    upd.descriptor              = data_byte_i;
          OFF_KI_HI:   upd.key_info[15:8]          = data_byte_i;
          OFF_KI_LO:   upd.key_info[7:0]           = data_byte_i;
          default:     upd.descriptor              = st_q.descriptor;
        endcase
      end
    end

    // Clear per-frame state after the last byte, else advance the position
    if (last_byte_i) begin
      st_d    = '0;
      qos_d   = 1'b0;
      count_d = '0;
    end else begin
      st_d = upd;
      if (count_q != '1) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      qos_q   <= 1'b0;
      count_q <= '0;
    end else if (take_i) begin
      st_q    <= st_d;
      qos_q   <= qos_d;
      count_q <= count_d;
    end
  end

  assign push_o = take_i && last_byte_i;
  assign rec_o  = upd;
  assign pos_o  = count_q;

endmodule

`default_nettype wire

// ===== hdl/ekpc_queue.sv =====
`default_nettype none

module ekpc_queue
  import ekpc_pkg::*;
#(
  parameter int DEPTH  = QUEUE_DEPTH_DEF,
  parameter int DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output      logic              full_o,
  output      logic              valid_o,
  output      logic [DATA_W-1:0] data_o,
  input  wire logic              pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !pop_i && !push_i |=> valid_o) else $error("queue entry lost");

endmodule

`default_nettype wire

// ===== hdl/ekpc_back.sv =====
`default_nettype none

module ekpc_back
  import ekpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   rec_valid_i,
  input  wire frame_rec_t             rec_i,
  input  wire logic [COUNT_WIDTH-1:0] pos_i,
  output      logic                   pop_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic                   accepted_o,
  output      logic [5:0]             header_bytes_o,
  output      logic [1:0]             eapol_version_o,
  output      logic [7:0]             packet_kind_o,
  output      logic [15:0]            body_length_o,
  output      logic                   is_key_o,
  output      logic [7:0]             descriptor_kind_o,
  output      logic [15:0]            key_information_o,
  output      logic                   pairwise_key_o,
  output      logic [2:0]             phase_o
);

  localparam int LW = COUNT_WIDTH + 1;
  localparam int AW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  function automatic logic [2:0] key_phase(input logic [15:0] ki);
    logic [2:0] ph;
    ph = PH_OTHER;
    if (ki[KI_PAIRWISE] && !ki[KI_ERROR] && !ki[KI_REQUEST]) begin
      if (ki[KI_ACK] && !ki[KI_MIC]) begin
        ph = PH_MSG1;
      end else if (!ki[KI_ACK] && ki[KI_MIC] && !ki[KI_SECURE]) begin
        ph = PH_MSG2;
      end else if (ki[KI_ACK] && ki[KI_MIC] && (ki[KI_SECURE] || ki[KI_INSTALL])) begin
        ph = PH_MSG3;
      end else if (!ki[KI_ACK] && ki[KI_MIC] && ki[KI_SECURE]) begin
        ph = PH_MSG4;
      end
    end
    return ph;
  endfunction

  logic [5:0]    thr;
  logic [LW-1:0] diff;
  logic          fits, body_fits, ver_ok, desc_ok, key_kind, ok;
  logic          out_valid_q, out_valid_d;

  logic        accepted_q;
  logic [5:0]  header_q;
  logic [1:0]  version_q;
  logic [7:0]  kind_q, desc_q;
  logic [15:0] body_q, ki_q;
  logic        is_key_q, pairwise_q;
  logic [2:0]  phase_q;

  // Room after the EAPOL header: position minus (header + 11)
  assign thr       = rec_i.hdr + HDR_TAIL;
  assign diff      = {1'b0, pos_i} - LW'(thr);
  assign fits      = !diff[LW-1];
  assign body_fits = AW'(rec_i.body_length) <= AW'(diff[COUNT_WIDTH-1:0]);
  assign ver_ok    = (rec_i.version >= VER_MIN) && (rec_i.version <= VER_MAX);
  assign desc_ok   = (rec_i.descriptor == DESC_RC4) || (rec_i.descriptor == DESC_RSN)
                  || (rec_i.descriptor == DESC_WPA);
  assign key_kind  = (rec_i.kind == KIND_KEY);
  assign ok        = (pos_i != '0) && (rec_i.ftype == FTYPE_DATA) && rec_i.snap && fits
                  && ver_ok && body_fits
                  && (!key_kind || ((rec_i.body_length >= KEY_MIN_BODY) && desc_ok));

  assign pop_o = rec_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      accepted_q <= ok;
      header_q   <= ok ? rec_i.hdr : 6'd0;
      version_q  <= ok ? rec_i.version[1:0] : 2'd0;
      kind_q     <= ok ? rec_i.kind : 8'd0;
      body_q     <= ok ? rec_i.body_length : 16'd0;
      is_key_q   <= ok && key_kind;
      desc_q     <= (ok && key_kind) ? rec_i.descriptor : 8'd0;
      ki_q       <= (ok && key_kind) ? rec_i.key_info : 16'd0;
      pairwise_q <= ok && key_kind && rec_i.key_info[KI_PAIRWISE];
      phase_q    <= (ok && key_kind) ? key_phase(rec_i.key_info) : PH_NONE;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign header_bytes_o    = header_q;
  assign eapol_version_o   = version_q;
  assign packet_kind_o     = kind_q;
  assign body_length_o     = body_q;
  assign is_key_o          = is_key_q;
  assign descriptor_kind_o = desc_q;
  assign key_information_o = ki_q;
  assign pairwise_key_o    = pairwise_q;
  assign phase_o           = phase_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> (header_bytes_o == 6'd0) && (phase_o == PH_NONE)
      && !is_key_o) else $error("rejected frame carries fields");
  a_key_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_key_o |-> accepted_o && (phase_o != PH_NONE))
    else $error("key result without phase");
  a_header_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> (header_bytes_o >= HDR_BASE))
    else $error("accepted frame with short header");

endmodule

`default_nettype wire

// ===== hdl/eapol_key_phase_classifier_top.sv =====
// The last byte pushes the frame summary into the queue; the back stage registers the result.
// Unstalled throughput: one byte per cycle, one result per cycle for back-to-back short frames.
// The parser updates on every byte; a two-entry queue and the output register take up stalls.
// Input stall rises only when the frame queue is full behind a stalled output.
// Reset (rst_ni low, asynchronous) clears the byte position, frame state, queue and valid.
`default_nettype none

module eapol_key_phase_classifier_top
  import ekpc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        accepted_o,
  output      logic [5:0]  header_bytes_o,
  output      logic [1:0]  eapol_version_o,
  output      logic [7:0]  packet_kind_o,
  output      logic [15:0] body_length_o,
  output      logic        is_key_o,
  output      logic [7:0]  descriptor_kind_o,
  output      logic [15:0] key_information_o,
  output      logic        pairwise_key_o,
  output      logic [2:0]  phase_o
);

  localparam int REC_W = $bits(frame_rec_t);
  localparam int Q_W   = REC_W + COUNT_WIDTH;

  logic                   take;
  logic                   push;
  frame_rec_t             front_rec, back_rec;
  logic [COUNT_WIDTH-1:0] front_pos, back_pos;
  logic                   q_full, q_valid, q_pop;
  logic [Q_W-1:0]         q_in, q_out;

  // Transfer a byte whenever the queue has room for a possible frame summary
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  // Front: track position, header length, SNAP match and EAPOL fields
  ekpc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .rec_o       (front_rec),
    .pos_o       (front_pos)
  );

  // Hold finished frame summaries until the classifier drains them
  assign q_in = {front_pos, front_rec};

  ekpc_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_out),
    .pop_i       (q_pop)
  );

  assign back_rec = q_out[REC_W-1:0];
  assign back_pos = q_out[Q_W-1:REC_W];

  // Back: type, SNAP, version, length and descriptor checks, phase decode, output register
  ekpc_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_valid_i       (q_valid),
    .rec_i             (back_rec),
    .pos_i             (back_pos),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .header_bytes_o    (header_bytes_o),
    .eapol_version_o   (eapol_version_o),
    .packet_kind_o     (packet_kind_o),
    .body_length_o     (body_length_o),
    .is_key_o          (is_key_o),
    .descriptor_kind_o (descriptor_kind_o),
    .key_information_o (key_information_o),
    .pairwise_key_o    (pairwise_key_o),
    .phase_o           (phase_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ekpc_pkg::*;

  // Run limit: the byte stream is about 2k bytes; even one-byte frames under the
  // heaviest idling and stalling finish well within this limit.
  localparam int CYCLE_LIMIT = 100_000;
  localparam int CNT_W       = COUNT_WIDTH_DEF;
  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam logic [63:0] SNAP_WORD = 64'hAAAA_0300_0000_888E;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic        accepted;
    logic [5:0]  header_bytes;
    logic [1:0]  eapol_version;
    logic [7:0]  packet_kind;
    logic [15:0] body_length;
    logic        is_key;
    logic [7:0]  descriptor_kind;
    logic [15:0] key_information;
    logic        pairwise_key;
    logic [2:0]  phase;
  } verdict_t;

  // DUT connections; every input starts at a known value
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        accepted_o;
  logic [5:0]  header_bytes_o;
  logic [1:0]  eapol_version_o;
  logic [7:0]  packet_kind_o;
  logic [15:0] body_length_o;
  logic        is_key_o;
  logic [7:0]  descriptor_kind_o;
  logic [15:0] key_information_o;
  logic        pairwise_key_o;
  logic [2:0]  phase_o;

  // Bytes waiting to be offered, and verdicts waiting for their result transfer
  frame_byte_t byte_q[$];
  frame_byte_t next_byte;
  verdict_t    verdicts_due[$];

  // Idle/stall odds (percent) for the current stretch of the run
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off, requested by the stimulus and counted down below
  logic hold_go   = 1'b0;
  int   hold_left = 0;

  // Shadow copy of the per-frame parser state
  int          byte_pos;
  logic [15:0] fc_word;
  logic [5:0]  hdr_len;
  logic        snap_ok;
  logic [7:0]  ver_cap;
  logic [7:0]  kind_cap;
  logic [15:0] blen_cap;
  logic [7:0]  desc_cap;
  logic [15:0] kinfo_cap;

  // Bookkeeping
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int results_seen  = 0;
  int accepted_seen = 0;
  int in_stall_seen = 0;
  int phase_seen[6];

  eapol_key_phase_classifier_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .header_bytes_o    (header_bytes_o),
    .eapol_version_o   (eapol_version_o),
    .packet_kind_o     (packet_kind_o),
    .body_length_o     (body_length_o),
    .is_key_o          (is_key_o),
    .descriptor_kind_o (descriptor_kind_o),
    .key_information_o (key_information_o),
    .pairwise_key_o    (pairwise_key_o),
    .phase_o           (phase_o)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Four-way handshake message from the key information bits
  function automatic logic [2:0] handshake_msg(input logic [15:0] ki);
    if (ki[KI_PAIRWISE] && !ki[KI_ERROR] && !ki[KI_REQUEST]) begin
      if (ki[KI_ACK] && !ki[KI_MIC]) return PH_MSG1;
      if (!ki[KI_ACK] && ki[KI_MIC] && !ki[KI_SECURE]) return PH_MSG2;
      if (ki[KI_ACK] && ki[KI_MIC] && (ki[KI_SECURE] || ki[KI_INSTALL])) return PH_MSG3;
      if (!ki[KI_ACK] && ki[KI_MIC] && ki[KI_SECURE]) return PH_MSG4;
    end
    return PH_OTHER;
  endfunction

  task automatic clear_parse();
    byte_pos  = 0;
    fc_word   = '0;
    hdr_len   = '0;
    snap_ok   = 1'b0;
    ver_cap   = '0;
    kind_cap  = '0;
    blen_cap  = '0;
    desc_cap  = '0;
    kinfo_cap = '0;
  endtask

  // Advance the shadow parser by one transferred byte; on the last byte,
  // queue the verdict for the frame and start over.
  task automatic track_byte(input logic [7:0] b, input logic lst);
    int       rel, len, avail;
    logic     ok;
    verdict_t v;
    if (byte_pos == 0) begin
      fc_word = {8'h00, b};
      snap_ok = 1'b1;
    end else if (byte_pos == 1) begin
      fc_word[15:8] = b;
      hdr_len = HDR_BASE + ((b[1:0] == 2'b11) ? HDR_ADDR4 : 6'd0)
              + (fc_word[7] ? HDR_QOS : 6'd0);
    end else if (byte_pos >= int'(hdr_len)) begin
      rel = byte_pos - int'(hdr_len);
      if (rel < 8) begin
        if (b != SNAP_WORD[63 - 8 * rel -: 8]) snap_ok = 1'b0;
      end else if (rel == OFF_VERSION) ver_cap = b;
      else if (rel == OFF_KIND) kind_cap = b;
      else if (rel == OFF_LEN_HI) blen_cap[15:8] = b;
      else if (rel == OFF_LEN_LO) blen_cap[7:0] = b;
      else if (rel == OFF_DESC) desc_cap = b;
      else if (rel == OFF_KI_HI) kinfo_cap[15:8] = b;
      else if (rel == OFF_KI_LO) kinfo_cap[7:0] = b;
    end

    if (!lst) begin
      // Saturate the position on very long frames
      if (byte_pos < CNT_MAX) byte_pos++;
      return;
    end

    len = byte_pos + 1;
    ok  = 1'b1;
    if (len < 2) ok = 1'b0;
    else if (fc_word[3:2] != FTYPE_DATA) ok = 1'b0;
    else if (int'(hdr_len) > len || len < int'(hdr_len) + 8 || !snap_ok) ok = 1'b0;
    else if (len < int'(hdr_len) + 12) ok = 1'b0;
    else if (ver_cap < VER_MIN || ver_cap > VER_MAX) ok = 1'b0;
    else begin
      avail = len - int'(hdr_len) - 12;
      if (int'(blen_cap) > avail) ok = 1'b0;
      else if (kind_cap == KIND_KEY) begin
        if (blen_cap < KEY_MIN_BODY || avail < int'(KEY_MIN_BODY)) ok = 1'b0;
        else if (desc_cap != DESC_RC4 && desc_cap != DESC_RSN && desc_cap != DESC_WPA)
          ok = 1'b0;
      end
    end

    v = '0;
    v.phase = PH_NONE;
    if (ok) begin
      v.accepted      = 1'b1;
      v.header_bytes  = hdr_len;
      v.eapol_version = ver_cap[1:0];
      v.packet_kind   = kind_cap;
      v.body_length   = blen_cap;
      if (kind_cap == KIND_KEY) begin
        v.is_key          = 1'b1;
        v.descriptor_kind = desc_cap;
        v.key_information = kinfo_cap;
        v.pairwise_key    = kinfo_cap[KI_PAIRWISE];
        v.phase           = handshake_msg(kinfo_cap);
      end
    end
    verdicts_due.push_back(v);
    clear_parse();
  endtask

  // Driver: predict on each input transfer, then offer the next byte or idle.
  // A stalled byte stays put until it transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'h00;
      last_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) track_byte(data_byte_i, last_byte_i);
      if (in_valid_i && in_stall_o) in_stall_seen++;
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_byte.data;
          last_byte_i <= next_byte.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off once requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Compare one result transfer against the oldest pending verdict
  task automatic check_result();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("result transfer with no frame verdict pending");
      fail_cnt++;
      return;
    end
    want = verdicts_due.pop_front();
    check_field("accepted", 32'(want.accepted), 32'(accepted_o));
    check_field("header_bytes", 32'(want.header_bytes), 32'(header_bytes_o));
    check_field("eapol_version", 32'(want.eapol_version), 32'(eapol_version_o));
    check_field("packet_kind", 32'(want.packet_kind), 32'(packet_kind_o));
    check_field("body_length", 32'(want.body_length), 32'(body_length_o));
    check_field("is_key", 32'(want.is_key), 32'(is_key_o));
    check_field("descriptor_kind", 32'(want.descriptor_kind), 32'(descriptor_kind_o));
    check_field("key_information", 32'(want.key_information), 32'(key_information_o));
    check_field("pairwise_key", 32'(want.pairwise_key), 32'(pairwise_key_o));
    check_field("phase", 32'(want.phase), 32'(phase_o));
    results_seen++;
    if (want.accepted) accepted_seen++;
    phase_seen[want.phase]++;
  endtask

  // Monitor: check each result transfer, then pick the stall for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    frame_byte_t fb;
    fb.data = b;
    fb.last = lst;
    byte_q.push_back(fb);
    bytes_sent++;
    if (lst) frames_sent++;
  endtask

  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
  endtask

  // Queue a data frame carrying LLC/SNAP and an EAPOL header. The frame ends
  // body bytes after the EAPOL header; a negative body cuts it short.
  task automatic send_eapol(input logic [7:0] fc0, input logic [7:0] fc1,
                            input logic [7:0] ver, input logic [7:0] kind,
                            input logic [15:0] blen, input logic [7:0] desc,
                            input logic [15:0] ki, input int body, input bit snap_bad);
    int         hdr, total, rel, bad_at;
    logic [7:0] b, flip;
    hdr    = 24 + ((fc1[1:0] == 2'b11) ? 6 : 0) + (fc0[7] ? 2 : 0);
    total  = hdr + 12 + body;
    bad_at = $urandom_range(7);
    flip   = 8'($urandom_range(255, 1));
    if (total < 1) total = 1;
    for (int i = 0; i < total; i++) begin
      rel = i - hdr;
      if (i == 0) b = fc0;
      else if (i == 1) b = fc1;
      else if (rel < 0) b = 8'($urandom);
      else if (rel < 8)
        b = SNAP_WORD[63 - 8 * rel -: 8] ^ ((snap_bad && rel == bad_at) ? flip : 8'h00);
      else if (rel == OFF_VERSION) b = ver;
      else if (rel == OFF_KIND) b = kind;
      else if (rel == OFF_LEN_HI) b = blen[15:8];
      else if (rel == OFF_LEN_LO) b = blen[7:0];
      else if (rel == OFF_DESC) b = desc;
      else if (rel == OFF_KI_HI) b = ki[15:8];
      else if (rel == OFF_KI_LO) b = ki[7:0];
      else b = 8'($urandom);
      push_byte(b, i == total - 1);
    end
  endtask

  // Handshake key frames with random content for 45 percent of picks; the rest are
  // other EAPOL packets, broken frames and plain noise.
  task automatic send_random_frame();
    int          pick, body;
    logic [7:0]  fc0, fc1, ver, kind, desc;
    logic [15:0] blen, ki;
    pick = $urandom_range(99);
    fc0  = (8'($urandom) & 8'hF3) | 8'h08;
    fc1  = 8'($urandom);
    ver  = 8'($urandom_range(3, 1));
    ki   = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      ki[KI_PAIRWISE] = 1'b1;
      ki[KI_ERROR]    = 1'b0;
      ki[KI_REQUEST]  = 1'b0;
    end
    case ($urandom_range(3))
      0: desc = DESC_RC4;
      1: desc = DESC_RSN;
      2: desc = DESC_WPA;
      default: desc = 8'($urandom);
    endcase
    body = 95 + $urandom_range(6);
    blen = 16'(body - $urandom_range(3));
    if ($urandom_range(9) == 0) blen = 16'(body + 1);

    if (pick < 45) begin
      send_eapol(fc0, fc1, ver, KIND_KEY, blen, desc, ki, body, 1'b0);
    end else if (pick < 65) begin
      kind = 8'($urandom);
      if (kind == KIND_KEY) kind = 8'd1;
      body = $urandom_range(12);
      blen = 16'($urandom_range(body));
      if ($urandom_range(9) == 0) blen = 16'(body + 1);
      send_eapol(fc0, fc1, ver, kind, blen, desc, ki, body, 1'b0);
    end else if (pick < 80) begin
      // Break the length, the version or the frame type; the SNAP is broken for picks below 70
      case ($urandom_range(3))
        0: body = $urandom_range(100) - 50;
        1: ;
        2: ver = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(255, 4));
        default: fc0 = 8'($urandom);
      endcase
      send_eapol(fc0, fc1, ver, KIND_KEY, blen, desc, ki, body, pick < 70);
    end else begin
      send_noise($urandom_range(40, 1));
    end
  endtask

  // Wait until every queued byte has transferred and every verdict is checked
  task automatic drain();
    while (byte_q.size() != 0 || in_valid_i || verdicts_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct);
    int start_bytes, start_frames;
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes    = bytes_sent;
    start_frames   = frames_sent;
    while (bytes_sent - start_bytes < 120 || frames_sent - start_frames < 2)
      send_random_frame();
    drain();
  endtask

  initial begin
    clear_parse();
    foreach (phase_seen[i]) phase_seen[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames, no idling
    send_noise(1);
    send_noise(2);
    // Cut inside the MAC header, after the SNAP, inside the EAPOL header
    send_eapol(8'h08, 8'h01, 8'd2, KIND_KEY, 16'd95, DESC_RSN, 16'h008A, -20, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd2, KIND_KEY, 16'd95, DESC_RSN, 16'h008A, -4, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd2, KIND_KEY, 16'd95, DESC_RSN, 16'h008A, -1, 1'b0);
    // The four handshake messages over every header shape
    send_eapol(8'h08, 8'h02, 8'd2, KIND_KEY, 16'd95, DESC_RSN, 16'h008A, 95, 1'b0);
    send_eapol(8'h88, 8'h01, 8'd1, KIND_KEY, 16'd97, DESC_WPA, 16'h0109, 99, 1'b0);
    send_eapol(8'h88, 8'h03, 8'd2, KIND_KEY, 16'd100, DESC_RSN, 16'h13CA, 120, 1'b0);
    send_eapol(8'h08, 8'h03, 8'd2, KIND_KEY, 16'd95, DESC_RSN, 16'h01CA, 95, 1'b0);
    send_eapol(8'h08, 8'h03, 8'd3, KIND_KEY, 16'd95, DESC_RC4, 16'h030A, 95, 1'b0);
    // Rejections: bad descriptor, short key body
    send_eapol(8'h08, 8'h01, 8'd2, KIND_KEY, 16'd95, 8'h00, 16'h008A, 95, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd2, KIND_KEY, 16'd94, DESC_RSN, 16'h008A, 95, 1'b0);
    // Rejections: version out of range, frame type not data, broken SNAP
    send_eapol(8'h08, 8'h01, 8'd0, 8'd1, 16'd0, DESC_RSN, 16'h0000, 0, 1'b0);
    send_eapol(8'h08, 8'h01, 8'hFF, 8'd1, 16'd0, DESC_RSN, 16'h0000, 0, 1'b0);
    send_eapol(8'h0C, 8'h01, 8'd2, 8'd1, 16'd0, DESC_RSN, 16'h0000, 0, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd2, 8'd1, 16'd0, DESC_RSN, 16'h0000, 0, 1'b1);
    // Non-key packets: empty start that fits exactly, short length, overlong length
    send_eapol(8'h08, 8'h01, 8'd1, 8'd1, 16'd0, 8'h00, 16'h0000, 0, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd3, 8'hFF, 16'd3, 8'h00, 16'h0000, 10, 1'b0);
    send_eapol(8'h08, 8'h01, 8'd2, 8'd2, 16'd10, 8'h00, 16'h0000, 9, 1'b0);
    drain();

    // Random frames under each idling mix
    run_random(0, 0);
    run_random(68, 0);
    run_random(0, 68);
    run_random(30, 30);

    // Hold off the receiver while short frames stream in back to back, so the
    // frame queue fills and the input stalls
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    @(negedge clk_i);
    hold_go = 1'b0;
    for (int i = 0; i < 40; i++) send_noise($urandom_range(3, 1));
    drain();

    repeat (8) @(negedge clk_i);
    $display("Checked %0d verdicts (%0d accepted) from %0d frames, %0d bytes;",
             results_seen, accepted_seen, frames_sent, bytes_sent);
    $display("input stalled %0d cycles; key phases msg1 %0d, msg2 %0d, msg3 %0d, msg4 %0d, other %0d.",
             in_stall_seen, phase_seen[PH_MSG1], phase_seen[PH_MSG2], phase_seen[PH_MSG3],
             phase_seen[PH_MSG4], phase_seen[PH_OTHER]);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ekpc_pkg.sv
hdl/ekpc_front.sv
hdl/ekpc_queue.sv
hdl/ekpc_back.sv
hdl/eapol_key_phase_classifier_top.sv
tb/tb.sv
